// ===== hdl/circle_pair_collision_resolve_top_assert.svh =====
// ----------------------------------------------------------------------------
// Circle pair collision resolver assertion macros
// Shared property templates for the concurrent checks of the top level.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_PAIR_COLLISION_RESOLVE_TOP_ASSERT_SVH
`define CIRCLE_PAIR_COLLISION_RESOLVE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CPCR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cpcr check failed");

// Next-cycle implication, checked out of reset.
`define CPCR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cpcr check failed");

`endif

// ===== hdl/cpcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision resolver package
// Payload types, job and carry records, widths and shared arithmetic helpers.
// ----------------------------------------------------------------------------
package cpcr_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned RootW      = 32;      // sqrt result width
  localparam int unsigned QuoW       = RootW;   // divider quotient width
  localparam int unsigned NumW       = 64;
  localparam int unsigned DenW       = 33;
  localparam int unsigned RestW      = 17;
  localparam logic [RestW-1:0] RestReset = 17'd32768;
  localparam logic [17:0]      UnitQ16   = 18'd65536;
  localparam logic signed [41:0] ClipMax = 42'sd2147483647;
  localparam logic signed [41:0] ClipMin = -42'sd2147483648;

  typedef struct packed {
    logic signed [31:0] pos_x_a;
    logic signed [31:0] pos_y_a;
    logic signed [31:0] vel_x_a;
    logic signed [31:0] vel_y_a;
    logic [30:0]        radius_a;
    logic [30:0]        mass_a;
    logic signed [31:0] pos_x_b;
    logic signed [31:0] pos_y_b;
    logic signed [31:0] vel_x_b;
    logic signed [31:0] vel_y_b;
    logic [30:0]        radius_b;
    logic [30:0]        mass_b;
  } cpcr_in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x_a;
    logic signed [31:0] new_pos_y_a;
    logic signed [31:0] new_vel_x_a;
    logic signed [31:0] new_vel_y_a;
    logic signed [31:0] new_pos_x_b;
    logic signed [31:0] new_pos_y_b;
    logic signed [31:0] new_vel_x_b;
    logic signed [31:0] new_vel_y_b;
    logic               collided;
    logic               coincident;
    logic               saturated;
  } cpcr_out_t;

  // Classified pair, as it sits in the queue.
  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic               hit;
    logic               coin;
    logic               dx_neg;
    logic               dx_pos;
    logic               dy_neg;
    logic               dy_pos;
    logic [31:0]        adx;
    logic [31:0]        ady;
    logic [31:0]        rsum;
    logic [63:0]        sq;
    logic [48:0]        ka_num;
    logic [48:0]        kb_num;
    logic [31:0]        msum;
  } cpcr_job_t;

  // Late back-end record: separated positions and the normal.
  typedef struct packed {
    cpcr_job_t          job;
    logic [17:0]        ka;
    logic [17:0]        kb;
    logic signed [32:0] pax;
    logic signed [32:0] pay;
    logic signed [32:0] pbx;
    logic signed [32:0] pby;
    logic signed [29:0] nx;
    logic signed [29:0] ny;
  } cpcr_carry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cpcr_qstat_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } cpcr_clip_t;

  function automatic cpcr_clip_t clip32(input logic signed [41:0] v);
    cpcr_clip_t r;
    r.sat = 1'b0;
    r.val = v[31:0];
    if (v > ClipMax) begin
      r.sat = 1'b1;
      r.val = ClipMax[31:0];
    end else if (v < ClipMin) begin
      r.sat = 1'b1;
      r.val = ClipMin[31:0];
    end
    return r;
  endfunction

  // Arithmetic right shift that rounds toward zero.
  function automatic logic signed [68:0] rtz_shr(input logic signed [68:0] v,
                                                 input logic [4:0] sh);
    logic signed [68:0] bias;
    bias = v[68] ? ((69'sd1 <<< sh) - 69'sd1) : 69'sd0;
    return (v + bias) >>> sh;
  endfunction

endpackage

// ===== hdl/cpcr_front.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision resolver front end
// Takes pairs, forms center differences and squares, classifies the overlap.
// ----------------------------------------------------------------------------
module cpcr_front import cpcr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cpcr_in_t         in_data_i,
  input  logic [RestW-1:0] restitution_i,
  input  cpcr_qstat_t      qstat_i,
  output logic             push_o,
  output cpcr_job_t        job_o
);

  logic        adv;
  logic [32:0] dx, dy;

  logic        f1_valid_q;
  cpcr_in_t    f1_in_q;
  logic [31:0] f1_adx_q, f1_ady_q, f1_rsum_q;
  logic        f1_dxn_q, f1_dxp_q, f1_dyn_q, f1_dyp_q;
  logic [30:0] f1_ma_q, f1_mb_q;
  logic [17:0] f1_f_q;

  logic        f2_valid_q;
  cpcr_job_t   f2_job_q;
  logic [63:0] f2_r2_q;
  logic [63:0] f2_sy_q;

  logic [64:0] sq_sum;
  logic        quick, ovl;

  // Advance unless a finished pair cannot enter the queue.
  assign adv        = !f2_valid_q || !qstat_i.full;
  assign in_stall_o = !adv;

  assign dx = {in_data_i.pos_x_a[31], in_data_i.pos_x_a} -
              {in_data_i.pos_x_b[31], in_data_i.pos_x_b};
  assign dy = {in_data_i.pos_y_a[31], in_data_i.pos_y_a} -
              {in_data_i.pos_y_b[31], in_data_i.pos_y_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else if (adv) begin
      f1_valid_q <= in_valid_i;
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_in_q   <= in_data_i;
      f1_adx_q  <= dx[32] ? 32'(-dx) : dx[31:0];
      f1_ady_q  <= dy[32] ? 32'(-dy) : dy[31:0];
      f1_dxn_q  <= dx[32];
      f1_dxp_q  <= !dx[32] && (dx != '0);
      f1_dyn_q  <= dy[32];
      f1_dyp_q  <= !dy[32] && (dy != '0);
      f1_rsum_q <= {1'b0, in_data_i.radius_a} + {1'b0, in_data_i.radius_b};
      f1_ma_q   <= (in_data_i.mass_a == '0) ? 31'd1 : in_data_i.mass_a;
      f1_mb_q   <= (in_data_i.mass_b == '0) ? 31'd1 : in_data_i.mass_b;
      f1_f_q    <= UnitQ16 + {1'b0, restitution_i};

      f2_job_q.ax     <= f1_in_q.pos_x_a;
      f2_job_q.ay     <= f1_in_q.pos_y_a;
      f2_job_q.vax    <= f1_in_q.vel_x_a;
      f2_job_q.vay    <= f1_in_q.vel_y_a;
      f2_job_q.bx     <= f1_in_q.pos_x_b;
      f2_job_q.by     <= f1_in_q.pos_y_b;
      f2_job_q.vbx    <= f1_in_q.vel_x_b;
      f2_job_q.vby    <= f1_in_q.vel_y_b;
      f2_job_q.hit    <= 1'b0;
      f2_job_q.coin   <= 1'b0;
      f2_job_q.dx_neg <= f1_dxn_q;
      f2_job_q.dx_pos <= f1_dxp_q;
      f2_job_q.dy_neg <= f1_dyn_q;
      f2_job_q.dy_pos <= f1_dyp_q;
      f2_job_q.adx    <= f1_adx_q;
      f2_job_q.ady    <= f1_ady_q;
      f2_job_q.rsum   <= f1_rsum_q;
      // Hold the x square in sq until the sum is formed below.
      f2_job_q.sq     <= 64'(f1_adx_q) * 64'(f1_adx_q);
      f2_job_q.ka_num <= 49'(f1_mb_q) * 49'(f1_f_q);
      f2_job_q.kb_num <= 49'(f1_ma_q) * 49'(f1_f_q);
      f2_job_q.msum   <= {1'b0, f1_ma_q} + {1'b0, f1_mb_q};
      f2_r2_q         <= 64'(f1_rsum_q) * 64'(f1_rsum_q);
      f2_sy_q         <= 64'(f1_ady_q) * 64'(f1_ady_q);
    end
  end

  always_comb begin
    sq_sum = {1'b0, f2_job_q.sq} + {1'b0, f2_sy_q};
    quick  = (f2_job_q.adx <= f2_job_q.rsum) && (f2_job_q.ady <= f2_job_q.rsum);
    ovl    = quick && !sq_sum[64] && (sq_sum[63:0] <= f2_r2_q);
    job_o      = f2_job_q;
    job_o.sq   = sq_sum[63:0];
    job_o.hit  = ovl && (sq_sum[63:0] != '0);
    job_o.coin = ovl && (sq_sum[63:0] == '0);
  end

  assign push_o = f2_valid_q && !qstat_i.full;

endmodule

// ===== hdl/cpcr_queue.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision resolver job queue
// Short FIFO between the classifying front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module cpcr_queue import cpcr_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  cpcr_job_t   wdata_i,
  input  logic        pop_i,
  output cpcr_job_t   rdata_o,
  output cpcr_qstat_t qstat_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cpcr_job_t     mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign qstat_o.full  = (count_q == CntW'(DEPTH));
  assign qstat_o.empty = (count_q == '0);
  assign rdata_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= bump(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= bump(rd_ptr_q);
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

// ===== hdl/cpcr_sqrt.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision resolver square root
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cpcr_sqrt import cpcr_pkg::*; #(
  parameter int unsigned ROOT_W = RootW
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  output logic [ROOT_W-1:0]     root_o
);

  localparam int unsigned XW = 2 * ROOT_W;
  localparam int unsigned RW = ROOT_W + 3;

  logic [XW-1:0]     x_q    [ROOT_W];
  logic [RW-1:0]     rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [XW-1:0]     x_d    [ROOT_W];
  logic [RW-1:0]     rem_d  [ROOT_W];
  logic [ROOT_W-1:0] root_d [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [XW-1:0]     x_in;
    logic [RW-1:0]     rem_in, t, trial;
    logic [ROOT_W-1:0] root_in;
    if (s == 0) begin : g_first
      assign x_in    = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_rest
      assign x_in    = x_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end
    always_comb begin
      t         = {rem_in[RW-3:0], x_in[XW-1:XW-2]};
      trial     = {1'b0, root_in, 2'b01};
      x_d[s]    = {x_in[XW-3:0], 2'b00};
      if (t >= trial) begin
        rem_d[s]  = t - trial;
        root_d[s] = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d[s]  = t;
        root_d[s] = {root_in[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

// ===== hdl/cpcr_div.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision resolver divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cpcr_div import cpcr_pkg::*; #(
  parameter int unsigned NUM_W = NumW,
  parameter int unsigned DEN_W = DenW,
  parameter int unsigned QUO_W = QuoW
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  // Caller guarantees the quotient fits in QUO_W bits.
  localparam int unsigned AW = DEN_W + QUO_W;

  logic [AW-1:0]    acc_q [QUO_W];
  logic [AW-1:0]    acc_d [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [AW-1:0]    src;
    logic [DEN_W-1:0] dsrc;
    logic [AW:0]      sh;
    logic [DEN_W:0]   hi;
    if (s == 0) begin : g_first
      assign src  = AW'(num_i);
      assign dsrc = den_i;
    end else begin : g_rest
      assign src  = acc_q[s-1];
      assign dsrc = den_q[s-1];
    end
    always_comb begin
      sh       = {src, 1'b0};
      hi       = sh[AW:QUO_W];
      acc_d[s] = sh[AW-1:0];
      if (hi >= {1'b0, dsrc}) begin
        hi       = hi - {1'b0, dsrc};
        acc_d[s] = {hi[DEN_W-1:0], sh[QUO_W-1:1], 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q    <= acc_d;
      den_q[0] <= den_i;
      for (int i = 1; i < QUO_W; i++) den_q[i] <= den_q[i-1];
    end
  end

  assign quo_o = acc_q[QUO_W-1][QUO_W-1:0];

endmodule

// ===== hdl/cpcr_back.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision resolver back end
// Square root, separation, normal and impulse pipeline with output register.
// ----------------------------------------------------------------------------
module cpcr_back import cpcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cpcr_job_t   job_i,
  input  cpcr_qstat_t qstat_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output cpcr_out_t   out_data_o
);

  localparam int unsigned Lat = RootW;

  logic adv;

  // Leg one: square root and mass ratios.
  logic [Lat-1:0] v1_q;
  cpcr_job_t      j1_q [Lat];
  logic [RootW-1:0] root_dist;
  logic [QuoW-1:0]  ka_quo, kb_quo;

  logic        s1_v_q;
  cpcr_job_t   s1_j_q;
  logic [17:0] s1_ka_q, s1_kb_q;
  logic [31:0] s1_ov_q, s1_dist_q;

  logic        s2_v_q;
  cpcr_job_t   s2_j_q;
  logic [17:0] s2_ka_q, s2_kb_q;
  logic [63:0] s2_px_q, s2_py_q;
  logic [31:0] s2_dist_q;

  // Leg two: separation and normal division.
  logic [Lat-1:0] v2_q;
  cpcr_job_t      j2_q  [Lat];
  logic [17:0]    ka2_q [Lat];
  logic [17:0]    kb2_q [Lat];
  logic [QuoW-1:0] mx_quo, my_quo, nx_quo, ny_quo;

  logic               s3_v_q;
  cpcr_carry_t        s3_c_q, c3;
  logic signed [32:0] s3_dvx_q, s3_dvy_q;
  logic signed [31:0] mxs, mys;
  logic signed [29:0] nxs, nys;

  logic               s4_v_q;
  cpcr_carry_t        s4_c_q;
  logic signed [62:0] s4_px_q, s4_py_q;

  logic               s5_v_q;
  cpcr_carry_t        s5_c_q;
  logic signed [35:0] s5_dot_q;
  logic signed [63:0] dot_sum;
  logic signed [68:0] dot_wide;

  logic               s6_v_q;
  cpcr_carry_t        s6_c_q;
  logic signed [54:0] s6_qa_q, s6_qb_q;

  logic               s7_v_q;
  cpcr_carry_t        s7_c_q;
  logic signed [38:0] s7_qa_q, s7_qb_q;
  logic signed [68:0] qa_wide, qb_wide;

  logic               s8_v_q;
  cpcr_carry_t        s8_c_q;
  logic signed [68:0] s8_dax_q, s8_day_q, s8_dbx_q, s8_dby_q;

  logic        out_valid_q;
  cpcr_out_t   out_q, out_d;
  cpcr_clip_t  c_pax, c_pay, c_vax, c_vay, c_pbx, c_pby, c_vbx, c_vby;
  logic signed [40:0] dax, day, dbx, dby;

  // Freeze the whole pipeline while a result waits.
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && !qstat_i.empty;

  cpcr_sqrt #(.ROOT_W(RootW)) u_sqrt (
    .clk_i (clk_i), .en_i (adv), .rad_i (job_i.sq), .root_o (root_dist)
  );

  cpcr_div u_div_ka (
    .clk_i (clk_i), .en_i (adv), .num_i (NumW'(job_i.ka_num)),
    .den_i ({1'b0, job_i.msum}), .quo_o (ka_quo)
  );
  cpcr_div u_div_kb (
    .clk_i (clk_i), .en_i (adv), .num_i (NumW'(job_i.kb_num)),
    .den_i ({1'b0, job_i.msum}), .quo_o (kb_quo)
  );

  cpcr_div u_div_mx (
    .clk_i (clk_i), .en_i (adv), .num_i (s2_px_q),
    .den_i ({s2_dist_q, 1'b0}), .quo_o (mx_quo)
  );
  cpcr_div u_div_my (
    .clk_i (clk_i), .en_i (adv), .num_i (s2_py_q),
    .den_i ({s2_dist_q, 1'b0}), .quo_o (my_quo)
  );
  cpcr_div u_div_nx (
    .clk_i (clk_i), .en_i (adv), .num_i ({4'b0, s2_j_q.adx, 28'b0}),
    .den_i ({1'b0, s2_dist_q}), .quo_o (nx_quo)
  );
  cpcr_div u_div_ny (
    .clk_i (clk_i), .en_i (adv), .num_i ({4'b0, s2_j_q.ady, 28'b0}),
    .den_i ({1'b0, s2_dist_q}), .quo_o (ny_quo)
  );

  // Valid tracking through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      v2_q        <= '0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      s6_v_q      <= 1'b0;
      s7_v_q      <= 1'b0;
      s8_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= {v1_q[Lat-2:0], pop_o};
      s1_v_q      <= v1_q[Lat-1];
      s2_v_q      <= s1_v_q;
      v2_q        <= {v2_q[Lat-2:0], s2_v_q};
      s3_v_q      <= v2_q[Lat-1];
      s4_v_q      <= s3_v_q;
      s5_v_q      <= s4_v_q;
      s6_v_q      <= s5_v_q;
      s7_v_q      <= s6_v_q;
      s8_v_q      <= s7_v_q;
      out_valid_q <= s8_v_q;
    end
  end

  always_comb begin
    mxs = j2_q[Lat-1].dx_neg ? -$signed({1'b0, mx_quo[30:0]})
                             :  $signed({1'b0, mx_quo[30:0]});
    mys = j2_q[Lat-1].dy_neg ? -$signed({1'b0, my_quo[30:0]})
                             :  $signed({1'b0, my_quo[30:0]});
    nxs = j2_q[Lat-1].dx_pos ? -$signed({1'b0, nx_quo[28:0]})
                             :  $signed({1'b0, nx_quo[28:0]});
    nys = j2_q[Lat-1].dy_pos ? -$signed({1'b0, ny_quo[28:0]})
                             :  $signed({1'b0, ny_quo[28:0]});
  end

  always_comb begin
    c3     = '0;
    c3.job = j2_q[Lat-1];
    c3.ka  = ka2_q[Lat-1];
    c3.kb  = kb2_q[Lat-1];
    c3.pax = 33'(c3.job.ax) + 33'(mxs);
    c3.pay = 33'(c3.job.ay) + 33'(mys);
    c3.pbx = 33'(c3.job.bx) - 33'(mxs);
    c3.pby = 33'(c3.job.by) - 33'(mys);
    c3.nx  = nxs;
    c3.ny  = nys;
  end

  always_comb begin
    dot_sum  = 64'(s4_px_q) + 64'(s4_py_q);
    dot_wide = rtz_shr(69'(dot_sum), 5'd28);
    qa_wide  = rtz_shr(69'(s6_qa_q), 5'd16);
    qb_wide  = rtz_shr(69'(s6_qb_q), 5'd16);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      j1_q[0] <= job_i;
      for (int i = 1; i < Lat; i++) j1_q[i] <= j1_q[i-1];

      s1_j_q    <= j1_q[Lat-1];
      s1_ka_q   <= ka_quo[17:0];
      s1_kb_q   <= kb_quo[17:0];
      s1_dist_q <= root_dist;
      s1_ov_q   <= j1_q[Lat-1].rsum - root_dist;

      s2_j_q    <= s1_j_q;
      s2_ka_q   <= s1_ka_q;
      s2_kb_q   <= s1_kb_q;
      s2_dist_q <= s1_dist_q;
      s2_px_q   <= 64'(s1_ov_q) * 64'(s1_j_q.adx);
      s2_py_q   <= 64'(s1_ov_q) * 64'(s1_j_q.ady);

      j2_q[0]  <= s2_j_q;
      ka2_q[0] <= s2_ka_q;
      kb2_q[0] <= s2_kb_q;
      for (int i = 1; i < Lat; i++) begin
        j2_q[i]  <= j2_q[i-1];
        ka2_q[i] <= ka2_q[i-1];
        kb2_q[i] <= kb2_q[i-1];
      end

      s3_c_q   <= c3;
      s3_dvx_q <= 33'(c3.job.vax) - 33'(c3.job.vbx);
      s3_dvy_q <= 33'(c3.job.vay) - 33'(c3.job.vby);

      s4_c_q  <= s3_c_q;
      s4_px_q <= 63'(s3_dvx_q) * 63'(s3_c_q.nx);
      s4_py_q <= 63'(s3_dvy_q) * 63'(s3_c_q.ny);

      s5_c_q   <= s4_c_q;
      s5_dot_q <= dot_wide[35:0];

      s6_c_q  <= s5_c_q;
      s6_qa_q <= 55'($signed({1'b0, s5_c_q.ka})) * 55'(s5_dot_q);
      s6_qb_q <= 55'($signed({1'b0, s5_c_q.kb})) * 55'(s5_dot_q);

      s7_c_q  <= s6_c_q;
      s7_qa_q <= qa_wide[38:0];
      s7_qb_q <= qb_wide[38:0];

      s8_c_q   <= s7_c_q;
      s8_dax_q <= 69'(s7_qa_q) * 69'(s7_c_q.nx);
      s8_day_q <= 69'(s7_qa_q) * 69'(s7_c_q.ny);
      s8_dbx_q <= 69'(s7_qb_q) * 69'(s7_c_q.nx);
      s8_dby_q <= 69'(s7_qb_q) * 69'(s7_c_q.ny);

      out_q <= out_d;
    end
  end

  always_comb begin
    dax   = 41'(rtz_shr(s8_dax_q, 5'd28));
    day   = 41'(rtz_shr(s8_day_q, 5'd28));
    dbx   = 41'(rtz_shr(s8_dbx_q, 5'd28));
    dby   = 41'(rtz_shr(s8_dby_q, 5'd28));
    c_pax = clip32(42'(s8_c_q.pax));
    c_pay = clip32(42'(s8_c_q.pay));
    c_pbx = clip32(42'(s8_c_q.pbx));
    c_pby = clip32(42'(s8_c_q.pby));
    c_vax = clip32(42'(s8_c_q.job.vax) - 42'(dax));
    c_vay = clip32(42'(s8_c_q.job.vay) - 42'(day));
    c_vbx = clip32(42'(s8_c_q.job.vbx) + 42'(dbx));
    c_vby = clip32(42'(s8_c_q.job.vby) + 42'(dby));
    if (s8_c_q.job.hit) begin
      out_d.new_pos_x_a = c_pax.val;
      out_d.new_pos_y_a = c_pay.val;
      out_d.new_vel_x_a = c_vax.val;
      out_d.new_vel_y_a = c_vay.val;
      out_d.new_pos_x_b = c_pbx.val;
      out_d.new_pos_y_b = c_pby.val;
      out_d.new_vel_x_b = c_vbx.val;
      out_d.new_vel_y_b = c_vby.val;
      out_d.collided    = 1'b1;
      out_d.coincident  = 1'b0;
      out_d.saturated   = c_pax.sat | c_pay.sat | c_vax.sat | c_vay.sat |
                          c_pbx.sat | c_pby.sat | c_vbx.sat | c_vby.sat;
    end else begin
      out_d.new_pos_x_a = s8_c_q.job.ax;
      out_d.new_pos_y_a = s8_c_q.job.ay;
      out_d.new_vel_x_a = s8_c_q.job.vax;
      out_d.new_vel_y_a = s8_c_q.job.vay;
      out_d.new_pos_x_b = s8_c_q.job.bx;
      out_d.new_pos_y_b = s8_c_q.job.by;
      out_d.new_vel_x_b = s8_c_q.job.vbx;
      out_d.new_vel_y_b = s8_c_q.job.vby;
      out_d.collided    = 1'b0;
      out_d.coincident  = s8_c_q.job.coin;
      out_d.saturated   = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/circle_pair_collision_resolve_top.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision resolver
// Separates two overlapping circles and applies a restitution impulse.
// ----------------------------------------------------------------------------
// The block takes one circle pair per clock cycle while the input is not
// stalled and returns one result per pair, in order. Each transfer on the
// input moves one pair; each transfer on the output moves its resolved
// positions, velocities and flags. The front end forms the center
// difference, the squares and the overlap class, the pair passes the queue,
// then the back end runs a 32-stage square root (the mass ratios divide
// alongside), forms the separation numerators, runs 32 divider stages for
// the push-out and the normal, and does the dot product, impulse scaling
// and saturation. Every unit is fully pipelined, so throughput is one pair
// per cycle while the output is not stalled. A stalled output freezes the
// back end; the queue then fills and the front end stalls the input once it
// is full. Restitution must be written through cfg_we_i / cfg_wdata_i only
// while no pair is in flight; the block itself does not enforce this.
module circle_pair_collision_resolve_top import cpcr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [RestW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cpcr_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cpcr_out_t        out_data_o
);

  logic [RestW-1:0] rest_q;
  logic             push, pop;
  cpcr_job_t        push_job, pop_job;
  cpcr_qstat_t      qstat;

  // Restitution register, Q1.16.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q <= RestReset;
    end else if (cfg_we_i) begin
      rest_q <= cfg_wdata_i;
    end
  end

  // Front end: accept and classify.
  cpcr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .restitution_i (rest_q),
    .qstat_i       (qstat),
    .push_o        (push),
    .job_o         (push_job)
  );

  // Queue: lets the front keep taking pairs while the back end is held.
  cpcr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .pop_i   (pop),
    .rdata_o (pop_job),
    .qstat_o (qstat)
  );

  // Back end: root, division, impulse, output register.
  cpcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`include "circle_pair_collision_resolve_top_assert.svh"

  // Never push into a full queue or pop an empty one.
  `CPCR_ASSERT_IMP(a_no_overflow, push, !qstat.full)
  `CPCR_ASSERT_IMP(a_no_underflow, pop, !qstat.empty)
  // A resolved pair is never also flagged as coincident.
  `CPCR_ASSERT_IMP(a_flags_excl, out_valid_o, !(out_data_o.collided && out_data_o.coincident))
  // Pass-through results cannot clip.
  `CPCR_ASSERT_IMP(a_pass_no_sat, out_valid_o && !out_data_o.collided, !out_data_o.saturated)

endmodule

// ===== tb/sv/circle_pair_collision_resolve_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle pair collision resolver testbench
// Streams directed and random circle pairs through the resolver under random
// idling on both sides, predicts every result with a local fixed-point model
// and compares the outputs field by field, in order.
// ----------------------------------------------------------------------------
module circle_pair_collision_resolve_top_tb;
  import cpcr_pkg::*;

  localparam int unsigned ClkPeriod  = 8;
  localparam int unsigned DrainWait  = 200;
  localparam int unsigned LongHold   = 300;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [RestW-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  cpcr_in_t         in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  cpcr_out_t        out_data_o;

  circle_pair_collision_resolve_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  cpcr_in_t  pending_pairs[$];
  cpcr_out_t expected_results[$];
  logic [RestW-1:0] restitution_q;
  int unsigned      error_count;
  int unsigned      pair_count;
  int unsigned      hit_count;
  int unsigned      coin_count;
  int unsigned      sat_count;
  bit               hold_rx;      // request a long receiver hold-off
  bit               hold_active;

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: resolve one pair exactly as the block should.
  // ---------------------------------------------------------------------------
  function automatic longint unsigned sqrt_floor(input longint unsigned x);
    longint unsigned res;
    longint unsigned bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > x) bits >>= 2;
    while (bits != 0) begin
      if (x >= res + bits) begin
        x = x - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res >>= 1;
      end
      bits >>= 2;
    end
    return res;
  endfunction

  // Signed divide truncating toward zero, as the fixed-point scaling needs.
  function automatic longint div_tz(input longint num, input longint den);
    return num / den;
  endfunction

  function automatic logic signed [31:0] clip_q16(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic cpcr_out_t resolve_pair(input cpcr_in_t p,
                                             input logic [RestW-1:0] rest);
    cpcr_out_t r;
    longint ax, ay, vax, vay, bx, by, vbx, vby, dx, dy;
    longint unsigned adx, ady, rsum, sx, sq, root_dist, ov, f, ma1, mb1;
    longint mx, my, nx, ny, ka, kb, dot, qa, qb;
    bit sat;
    ax = p.pos_x_a; ay = p.pos_y_a; vax = p.vel_x_a; vay = p.vel_y_a;
    bx = p.pos_x_b; by = p.pos_y_b; vbx = p.vel_x_b; vby = p.vel_y_b;
    sat = 1'b0;
    r = '0;
    dx = ax - bx;
    dy = ay - by;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    rsum = longint'(p.radius_a) + longint'(p.radius_b);
    if (adx <= rsum && ady <= rsum) begin
      sx = adx * adx;
      sq = sx + ady * ady;
      if (!(sq < sx) && sq <= rsum * rsum) begin
        if (sq == 0) begin
          r.coincident = 1'b1;
        end else begin
          root_dist = sqrt_floor(sq);
          ov = rsum - root_dist;
          mx = (ov * adx) / (2 * root_dist);
          my = (ov * ady) / (2 * root_dist);
          nx = (adx << 28) / root_dist;
          ny = (ady << 28) / root_dist;
          if (dx > 0) nx = -nx;
          if (dy > 0) ny = -ny;
          f = 65536 + rest;
          ma1 = (p.mass_a != 0) ? p.mass_a : 1;
          mb1 = (p.mass_b != 0) ? p.mass_b : 1;
          ka = (mb1 * f) / (ma1 + mb1);
          kb = (ma1 * f) / (ma1 + mb1);
          r.collided = 1'b1;
          if (dx < 0) mx = -mx;
          if (dy < 0) my = -my;
          ax += mx; ay += my;
          bx -= mx; by -= my;
          dot = div_tz((vax - vbx) * nx + (vay - vby) * ny, 64'sd1 << 28);
          qa = div_tz(ka * dot, 65536);
          qb = div_tz(kb * dot, 65536);
          vax -= div_tz(qa * nx, 64'sd1 << 28);
          vay -= div_tz(qa * ny, 64'sd1 << 28);
          vbx += div_tz(qb * nx, 64'sd1 << 28);
          vby += div_tz(qb * ny, 64'sd1 << 28);
        end
      end
    end
    r.new_pos_x_a = clip_q16(ax, sat);
    r.new_pos_y_a = clip_q16(ay, sat);
    r.new_vel_x_a = clip_q16(vax, sat);
    r.new_vel_y_a = clip_q16(vay, sat);
    r.new_pos_x_b = clip_q16(bx, sat);
    r.new_pos_y_b = clip_q16(by, sat);
    r.new_vel_x_b = clip_q16(vbx, sat);
    r.new_vel_y_b = clip_q16(vby, sat);
    r.saturated   = sat;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer pending pairs with a random gap before each one. The
  // expectation is queued at the accepting edge, under the restitution then
  // in force (writes only happen while idle).
  // ---------------------------------------------------------------------------
  int unsigned tx_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      tx_gap     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(resolve_pair(in_data_i, restitution_q));
        pair_count++;
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled payload
      end else if (tx_gap != 0) begin
        in_valid_i <= 1'b0;
        tx_gap     <= tx_gap - 1;
      end else if (pending_pairs.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_pairs.pop_front();
        // draw the gap that follows this transfer; none during bursts
        tx_gap     <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stall per result, long hold-off on request, then compare.
  // ---------------------------------------------------------------------------
  int unsigned rx_wait;
  always @(posedge clk_i or negedge rst_ni) begin
    cpcr_out_t exp_r;
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
      rx_wait     <= 0;
      hold_active <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected");
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data_o.new_pos_x_a !== exp_r.new_pos_x_a) begin
            $error("new_pos_x_a exp %0d got %0d", exp_r.new_pos_x_a, out_data_o.new_pos_x_a);
            error_count++;
          end
          if (out_data_o.new_pos_y_a !== exp_r.new_pos_y_a) begin
            $error("new_pos_y_a exp %0d got %0d", exp_r.new_pos_y_a, out_data_o.new_pos_y_a);
            error_count++;
          end
          if (out_data_o.new_vel_x_a !== exp_r.new_vel_x_a) begin
            $error("new_vel_x_a exp %0d got %0d", exp_r.new_vel_x_a, out_data_o.new_vel_x_a);
            error_count++;
          end
          if (out_data_o.new_vel_y_a !== exp_r.new_vel_y_a) begin
            $error("new_vel_y_a exp %0d got %0d", exp_r.new_vel_y_a, out_data_o.new_vel_y_a);
            error_count++;
          end
          if (out_data_o.new_pos_x_b !== exp_r.new_pos_x_b) begin
            $error("new_pos_x_b exp %0d got %0d", exp_r.new_pos_x_b, out_data_o.new_pos_x_b);
            error_count++;
          end
          if (out_data_o.new_pos_y_b !== exp_r.new_pos_y_b) begin
            $error("new_pos_y_b exp %0d got %0d", exp_r.new_pos_y_b, out_data_o.new_pos_y_b);
            error_count++;
          end
          if (out_data_o.new_vel_x_b !== exp_r.new_vel_x_b) begin
            $error("new_vel_x_b exp %0d got %0d", exp_r.new_vel_x_b, out_data_o.new_vel_x_b);
            error_count++;
          end
          if (out_data_o.new_vel_y_b !== exp_r.new_vel_y_b) begin
            $error("new_vel_y_b exp %0d got %0d", exp_r.new_vel_y_b, out_data_o.new_vel_y_b);
            error_count++;
          end
          if (out_data_o.collided !== exp_r.collided) begin
            $error("collided exp %0b got %0b", exp_r.collided, out_data_o.collided);
            error_count++;
          end
          if (out_data_o.coincident !== exp_r.coincident) begin
            $error("coincident exp %0b got %0b", exp_r.coincident, out_data_o.coincident);
            error_count++;
          end
          if (out_data_o.saturated !== exp_r.saturated) begin
            $error("saturated exp %0b got %0b", exp_r.saturated, out_data_o.saturated);
            error_count++;
          end
          hit_count  += exp_r.collided;
          coin_count += exp_r.coincident;
          sat_count  += exp_r.saturated;
        end
      end
      // Stall pattern: a requested long hold-off, otherwise a random wait
      // drawn per result and counted down.
      if (hold_rx && !hold_active) begin
        hold_active <= 1'b1;
        rx_wait     <= LongHold;
        out_stall_i <= 1'b1;
      end else if (rx_wait != 0) begin
        rx_wait     <= rx_wait - 1;
        out_stall_i <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        // draw the wait for the next result
        if ($urandom_range(0, 3) == 0) begin
          out_stall_i <= 1'b0;
        end else begin
          rx_wait     <= $urandom_range(0, 15);
          out_stall_i <= 1'b1;
        end
      end else begin
        out_stall_i <= 1'b0;
      end
      if (!hold_rx) hold_active <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return $urandom_range(0, 65535 * 4) - 65536 * 2;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_u31(input bit for_mass);
    case ($urandom_range(0, 5))
      0:       return for_mass ? 31'd0 : 31'd0;
      1:       return 31'h7fffffff;
      2:       return 31'($urandom_range(1, 65536 * 16));
      default: return 31'($urandom);
    endcase
  endfunction

  // Noise pair: every field drawn over its full range.
  function automatic cpcr_in_t noise_pair();
    cpcr_in_t p;
    p.pos_x_a = rand_q16(); p.pos_y_a = rand_q16();
    p.vel_x_a = rand_q16(); p.vel_y_a = rand_q16();
    p.pos_x_b = rand_q16(); p.pos_y_b = rand_q16();
    p.vel_x_b = rand_q16(); p.vel_y_b = rand_q16();
    p.radius_a = rand_u31(0); p.radius_b = rand_u31(0);
    p.mass_a = rand_u31(1); p.mass_b = rand_u31(1);
    return p;
  endfunction

  // Overlapping pair: centre b near a, radii large enough to touch often.
  function automatic cpcr_in_t close_pair();
    cpcr_in_t p;
    int signed span;
    p = noise_pair();
    span = $urandom_range(1, 1 << $urandom_range(4, 26));
    p.pos_x_b = p.pos_x_a + $signed($urandom_range(0, 2 * span)) - span;
    p.pos_y_b = p.pos_y_a + $signed($urandom_range(0, 2 * span)) - span;
    p.radius_a = 31'($urandom_range(0, 2 * span));
    p.radius_b = 31'($urandom_range(0, 2 * span));
    if ($urandom_range(0, 7) == 0) p.pos_y_b = p.pos_y_a;
    if ($urandom_range(0, 15) == 0) p.pos_x_b = p.pos_x_a;
    return p;
  endfunction

  task automatic wait_idle();
    while (expected_results.size() != 0 || pending_pairs.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_restitution(input logic [RestW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    restitution_q = value;
  endtask

  initial begin
    #(ClkPeriod * 2_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    cpcr_in_t p;
    cpcr_in_t held_pairs[$];
    logic [RestW-1:0] rest_set[5];
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    hold_rx       = 1'b0;
    restitution_q = RestReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset restitution first, then extremes and special cases.
    p = '0;
    p.mass_a = 31'd65536; p.mass_b = 31'd65536;
    pending_pairs.push_back(p);                         // coincident centres
    p.pos_x_a = 32'sd65536; p.radius_a = 31'd65536; p.radius_b = 31'd65536;
    p.vel_x_a = -32'sd65536;
    pending_pairs.push_back(p);                         // head-on overlap
    p.pos_x_a = 32'sd131072;
    pending_pairs.push_back(p);                         // exactly touching
    p.pos_x_a = 32'sd131073;
    pending_pairs.push_back(p);                         // just apart
    p.mass_a = '0;
    p.pos_x_a = 32'sd1000;
    pending_pairs.push_back(p);                         // zero mass
    p.mass_b = '0;
    pending_pairs.push_back(p);
    p = '0;
    p.pos_x_a = 32'sh7fffffff; p.pos_x_b = 32'sh7fff0000;
    p.radius_a = 31'h7fffffff; p.radius_b = 31'h7fffffff;
    p.mass_a = 31'h7fffffff; p.mass_b = 31'd1;
    p.vel_x_a = 32'sh80000000; p.vel_x_b = 32'sh7fffffff;
    pending_pairs.push_back(p);                         // saturating push and impulse
    p.pos_y_a = 32'sh80000000; p.pos_y_b = 32'sh7fffffff;
    pending_pairs.push_back(p);                         // huge distance, quick test rejects
    p = '0;
    p.pos_x_a = 32'sh80000000; p.pos_x_b = 32'sh7fffffff;
    p.radius_a = 31'h7fffffff; p.radius_b = 31'h7fffffff;
    pending_pairs.push_back(p);                         // wide span, quick test fails by one
    repeat (10) pending_pairs.push_back(close_pair());
    wait_idle();

    rest_set[0] = '0;
    rest_set[1] = 17'd65536;
    rest_set[2] = 17'h1ffff;
    rest_set[3] = 17'($urandom_range(0, 17'h1ffff));
    rest_set[4] = RestReset;
    for (int ph = 0; ph < 5; ph++) begin
      write_restitution(rest_set[ph]);
      for (int i = 0; i < 130; i++)
        pending_pairs.push_back(($urandom_range(0, 3) == 0) ? noise_pair() : close_pair());
      if (ph == 1) begin
        // hold the receiver off while the sender keeps offering
        hold_rx = 1'b1;
        repeat (LongHold) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      if (ph == 2) begin
        // pause the sender until everything is back, then resume
        while (pending_pairs.size() > 65) @(posedge clk_i);
        held_pairs = pending_pairs;
        pending_pairs.delete();
        @(posedge clk_i);
        while (in_valid_i) @(posedge clk_i);
        while (expected_results.size() != 0) @(posedge clk_i);
        pending_pairs = held_pairs;
      end
      wait_idle();
    end

    $display("Covered %0d pairs: %0d collisions, %0d coincident, %0d saturated,",
             pair_count, hit_count, coin_count, sat_count);
    $display("over five restitution settings including zero, unity and maximum.");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
